[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion that is switched off while reset is high
`define BDC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// assertion that also holds across reset
`define BDC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[rtl/bdc_pkg.sv]
// ----------------------------------------------------------------------------
// bdc_pkg
// types, constants and calendar tables of the business day counter
// ----------------------------------------------------------------------------
package bdc_pkg;

  // field widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 22;
  localparam int Q100_W  = 8;   // year / 100 for a 14-bit year
  localparam int WSUM_W  = 15;  // weekday formula sum
  localparam int Q7_W    = 13;  // weekday sum / 7
  localparam int WD_W    = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // reciprocal constants: floor(x / 100) and floor(x / 7), exact over the input range
  localparam int RECIP100       = 5243;
  localparam int RECIP100_SHIFT = 19;
  localparam int PROD100_W      = 27;
  localparam int RECIP7         = 37450;
  localparam int RECIP7_SHIFT   = 18;
  localparam int PROD7_W        = 31;

  localparam int CENTURY    = 100;
  localparam int LEAP_CYCLE = 400;

  // months
  localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
  localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

  // weekdays, sunday first
  localparam logic [WD_W-1:0] WD_SUNDAY   = 3'd0;
  localparam logic [WD_W-1:0] WD_FRIDAY   = 3'd5;
  localparam logic [WD_W-1:0] WD_SATURDAY = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MOD,
    ST_CHECK,
    ST_WDAY,
    ST_STEP
  } bdc_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic year_en;
    logic mod_en;
    logic check_en;
    logic wday_en;
    logic step_en;
    logic result_en;
  } bdc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;
    logic empty;
    logic at_end;
    logic slot_free;
  } bdc_sts_t;

  // days in a month, zero for a month code that means nothing
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // (31 * mm) / 12 of the weekday formula, with march as mm = 1
  function automatic logic [DAY_W-1:0] month_shift(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] s;
    case (m)
      4'd1:    s = 5'd28;
      4'd2:    s = 5'd31;
      4'd3:    s = 5'd2;
      4'd4:    s = 5'd5;
      4'd5:    s = 5'd7;
      4'd6:    s = 5'd10;
      4'd7:    s = 5'd12;
      4'd8:    s = 5'd15;
      4'd9:    s = 5'd18;
      4'd10:   s = 5'd20;
      4'd11:   s = 5'd23;
      4'd12:   s = 5'd25;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // year / 100 by reciprocal multiply
  function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W-1:0] y);
    logic [PROD100_W-1:0] p;
    p = PROD100_W'(y) * PROD100_W'(RECIP100);
    return Q100_W'(p >> RECIP100_SHIFT);
  endfunction

endpackage

[rtl/bdc_in_if.sv]
// ----------------------------------------------------------------------------
// bdc_in_if
// input channel: one word carries a start date and an end date
// ----------------------------------------------------------------------------
interface bdc_in_if import bdc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  start_year;
  logic [MONTH_W-1:0] start_month;
  logic [DAY_W-1:0]   start_day;
  logic [YEAR_W-1:0]  end_year;
  logic [MONTH_W-1:0] end_month;
  logic [DAY_W-1:0]   end_day;

  modport source (
    output valid, start_year, start_month, start_day, end_year, end_month, end_day,
    input  ready
  );

  modport sink (
    input  valid, start_year, start_month, start_day, end_year, end_month, end_day,
    output ready
  );
endinterface

[rtl/bdc_out_if.sv]
// ----------------------------------------------------------------------------
// bdc_out_if
// output channel: one word carries the business day count and the bad date flag
// ----------------------------------------------------------------------------
interface bdc_out_if import bdc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] business_days;
  logic               bad_date;

  modport source (
    output valid, business_days, bad_date,
    input  ready
  );

  modport sink (
    input  valid, business_days, bad_date,
    output ready
  );
endinterface

[rtl/bdc_ctrl.sv]
// ----------------------------------------------------------------------------
// bdc_ctrl
// sequencer: setup steps for leap years and weekday, then one day per cycle
// ----------------------------------------------------------------------------
module bdc_ctrl import bdc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  bdc_sts_t sts,
  output bdc_cmd_t cmd
);

  bdc_state_t state;
  bdc_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_YEAR;
      end
      ST_YEAR:  state_next = ST_MOD;
      ST_MOD:   state_next = ST_CHECK;
      ST_CHECK: state_next = ST_WDAY;
      ST_WDAY: begin
        if (sts.bad || sts.empty) begin
          if (sts.slot_free) state_next = ST_IDLE;
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (sts.at_end && sts.slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_YEAR:  cmd.year_en  = 1'b1;
      ST_MOD:   cmd.mod_en   = 1'b1;
      ST_CHECK: cmd.check_en = 1'b1;
      ST_WDAY: begin
        cmd.wday_en = 1'b1;
        if (sts.bad || sts.empty) cmd.result_en = sts.slot_free;
      end
      ST_STEP: begin
        if (sts.at_end) begin
          cmd.result_en = sts.slot_free;
        end else begin
          cmd.step_en = 1'b1;
        end
      end
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[rtl/bdc_datapath.sv]
// ----------------------------------------------------------------------------
// bdc_datapath
// date registers, leap and weekday setup, day stepping counter, output word
// ----------------------------------------------------------------------------
module bdc_datapath import bdc_pkg::*; #(
  parameter int MAX_YEAR = 9999
) (
  input  logic               clk,
  input  logic               rst,
  input  bdc_cmd_t           cmd,
  output bdc_sts_t           sts,
  input  logic [YEAR_W-1:0]  start_year,
  input  logic [MONTH_W-1:0] start_month,
  input  logic [DAY_W-1:0]   start_day,
  input  logic [YEAR_W-1:0]  end_year,
  input  logic [MONTH_W-1:0] end_month,
  input  logic [DAY_W-1:0]   end_day,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COUNT_W-1:0] business_days,
  output logic               bad_date
);

  localparam logic [YEAR_W-1:0] MaxYear = YEAR_W'(MAX_YEAR);
  localparam logic [6:0]        LastOfCentury = 7'(CENTURY - 1);
  localparam logic [8:0]        LastOfCycle   = 9'(LEAP_CYCLE - 1);

  // current date, starts at the start date
  logic [YEAR_W-1:0]  cur_y;
  logic [MONTH_W-1:0] cur_m;
  logic [DAY_W-1:0]   cur_d;
  logic [6:0]         cur_mod100;
  logic [8:0]         cur_mod400;
  logic [YEAR_W-1:0]  ey;
  logic [MONTH_W-1:0] em;
  logic [DAY_W-1:0]   ed;

  // setup registers
  logic [Q100_W-1:0]  q_s;
  logic [Q100_W-1:0]  q_e;
  logic [Q100_W-1:0]  q_yy;
  logic               leap_e;
  logic [WSUM_W-1:0]  wsum;
  logic [Q7_W-1:0]    q7;
  logic               bad;
  logic               start_first;
  logic [WD_W-1:0]    wd;
  logic [COUNT_W-1:0] count;

  // combinational helpers
  logic [YEAR_W-1:0]  yy;
  logic [14:0]        hund_s;
  logic [14:0]        hund_e;
  logic [6:0]         r100_s;
  logic [6:0]         r100_e;
  logic [8:0]         m400_s;
  logic [8:0]         m400_e;
  logic               leap_cur;
  logic [DAY_W-1:0]   len_cur;
  logic               ok_s;
  logic               ok_e;
  logic [PROD7_W-1:0] prod7;
  logic [15:0]        sev_q;
  logic               at_end;

  // year of the weekday formula: january and february count to the year before
  assign yy = cur_y - YEAR_W'(cur_m <= FEBRUARY);

  // year mod 100 and mod 400 from the quotients
  assign hund_s = 15'(q_s) * 15'(CENTURY);
  assign hund_e = 15'(q_e) * 15'(CENTURY);
  assign r100_s = 7'(cur_y - hund_s[YEAR_W-1:0]);
  assign r100_e = 7'(ey - hund_e[YEAR_W-1:0]);
  assign m400_s = 9'(q_s[1:0]) * 9'(CENTURY) + 9'(r100_s);
  assign m400_e = 9'(q_e[1:0]) * 9'(CENTURY) + 9'(r100_e);

  // leap flag and month length of the current date
  assign leap_cur = ((cur_y[1:0] == 2'd0) && (cur_mod100 != 7'd0)) || (cur_mod400 == 9'd0);
  assign len_cur  = month_len(cur_m, leap_cur);

  // date validity
  assign ok_s = (cur_y != '0) && (cur_y <= MaxYear) && (cur_m >= JANUARY) &&
                (cur_m <= DECEMBER) && (cur_d != '0) && (cur_d <= len_cur);
  assign ok_e = (ey != '0) && (ey <= MaxYear) && (em >= JANUARY) && (em <= DECEMBER) &&
                (ed != '0) && (ed <= month_len(em, leap_e));

  // weekday sum / 7 and the remainder
  assign prod7 = PROD7_W'(wsum) * PROD7_W'(RECIP7);
  assign sev_q = 16'(q7) * 16'd7;

  assign at_end = ({cur_y, cur_m, cur_d} == {ey, em, ed});

  // date registers and day stepping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_y <= start_year;
      cur_m <= start_month;
      cur_d <= start_day;
      ey    <= end_year;
      em    <= end_month;
      ed    <= end_day;
    end else if (cmd.step_en) begin
      if (cur_d == len_cur) begin
        cur_d <= DAY_W'(1);
        if (cur_m == DECEMBER) begin
          cur_m <= JANUARY;
          cur_y <= cur_y + YEAR_W'(1);
        end else begin
          cur_m <= cur_m + MONTH_W'(1);
        end
      end else begin
        cur_d <= cur_d + DAY_W'(1);
      end
    end
  end

  // century position of the current year
  always_ff @(posedge clk) begin
    if (cmd.mod_en) begin
      cur_mod100 <= r100_s;
      cur_mod400 <= m400_s;
    end else if (cmd.step_en && (cur_d == len_cur) && (cur_m == DECEMBER)) begin
      cur_mod100 <= (cur_mod100 == LastOfCentury) ? 7'd0 : cur_mod100 + 7'd1;
      cur_mod400 <= (cur_mod400 == LastOfCycle) ? 9'd0 : cur_mod400 + 9'd1;
    end
  end

  // setup: quotients, end leap flag, weekday sum, checks, weekday sum / 7
  always_ff @(posedge clk) begin
    if (cmd.year_en) begin
      q_s  <= div100(cur_y);
      q_e  <= div100(ey);
      q_yy <= div100(yy);
    end
    if (cmd.mod_en) begin
      leap_e <= ((ey[1:0] == 2'd0) && (r100_e != 7'd0)) || (m400_e == 9'd0);
      wsum   <= WSUM_W'(cur_d) + WSUM_W'(yy) + WSUM_W'(yy >> 2) - WSUM_W'(q_yy) +
                WSUM_W'(q_yy >> 2) + WSUM_W'(month_shift(cur_m));
    end
    if (cmd.check_en) begin
      bad         <= !(ok_s && ok_e);
      start_first <= ({cur_y, cur_m, cur_d} < {ey, em, ed});
      q7          <= Q7_W'(prod7 >> RECIP7_SHIFT);
    end
  end

  // weekday and saturating business day count
  always_ff @(posedge clk) begin
    if (cmd.wday_en) begin
      wd <= WD_W'(wsum - sev_q[WSUM_W-1:0]);
    end else if (cmd.step_en) begin
      wd <= (wd == WD_SATURDAY) ? WD_SUNDAY : wd + WD_W'(1);
    end
    if (cmd.load) begin
      count <= '0;
    end else if (cmd.step_en && (wd != WD_FRIDAY) && (wd != WD_SATURDAY) &&
                 (count != COUNT_MAX)) begin
      count <= count + COUNT_W'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_en) begin
      business_days <= count;
      bad_date      <= bad;
    end
  end

  // status to the controller
  assign sts.bad       = bad;
  assign sts.empty     = !start_first;
  assign sts.at_end    = at_end;
  assign sts.slot_free = !out_valid || out_ready;

endmodule

[rtl/business_day_counter_top.sv]
// ----------------------------------------------------------------------------
// business_day_counter_top
// business days between two gregorian dates
// ----------------------------------------------------------------------------
// Counts the days from the start date up to but not including the end date
// that are not a Friday or Saturday. Dates with a year outside 1..MAX_YEAR, a
// month outside 1..12 or a day outside the month give bad_date = 1 and a
// count of 0; a start on or after the end gives 0. One word is worked on at a
// time: after it is taken, the setup steps find the leap years, check both
// dates and work out the start weekday, then the calendar counter advances one
// day per cycle. The result sits in an output register, so the next word is
// taken while it waits to be read. The count saturates at 4194303.
module business_day_counter_top import bdc_pkg::*; #(
  parameter int MAX_YEAR = 9999
) (
  input  logic      clk,
  input  logic      rst,
  bdc_in_if.sink    dates,
  bdc_out_if.source result
);

  bdc_cmd_t           cmd;
  bdc_sts_t           sts;
  logic               in_ready;
  logic               out_valid;
  logic [COUNT_W-1:0] business_days;
  logic               bad_date;

  // controller
  bdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dates.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  bdc_datapath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .start_year    (dates.start_year),
    .start_month   (dates.start_month),
    .start_day     (dates.start_day),
    .end_year      (dates.end_year),
    .end_month     (dates.end_month),
    .end_day       (dates.end_day),
    .out_valid     (out_valid),
    .out_ready     (result.ready),
    .business_days (business_days),
    .bad_date      (bad_date)
  );

  // channel hookup
  assign dates.ready          = in_ready;
  assign result.valid         = out_valid;
  assign result.business_days = business_days;
  assign result.bad_date      = bad_date;

endmodule

[rtl/bdc_checker.sv]
// ----------------------------------------------------------------------------
// bdc_checker
// port level checks of the business day counter
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdc_checker import bdc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COUNT_W-1:0] business_days,
  input logic               bad_date
);

  // no result word right after reset
  `BDC_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !out_valid, "result valid after reset")

  // a waiting result word stays offered
  `BDC_ASSERT(a_out_held, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")

  // a bad date always reports a zero count
  `BDC_ASSERT(a_bad_zero, clk, rst, out_valid && bad_date |-> business_days == '0, "bad date with count")

  // the block is busy in the cycle after it takes a word
  `BDC_ASSERT(a_busy_after_accept, clk, rst, in_valid && in_ready |=> !in_ready, "took two words")

  // a new result word only comes out of a busy cycle
  `BDC_ASSERT(a_result_from_work, clk, rst, $rose(out_valid) |-> $past(!in_ready), "result from nowhere")

endmodule

bind business_day_counter_top bdc_checker u_bdc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (dates.valid),
  .in_ready      (dates.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .business_days (result.business_days),
  .bad_date      (result.bad_date)
);
